// ----- sv/isb_pkg.sv -----
// Shared types and constants for the image seam linear blend block.
package isb_pkg;

	localparam int MAX_COLS    = 4096;
	localparam int MAX_BLEND   = 256;
	localparam int COL_W       = 13;
	localparam int CUT_W       = 12;
	localparam int BLEND_W     = 9;
	localparam int PIX_W       = 16;
	localparam int BLEND_AW    = $clog2(MAX_BLEND);
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_FIRST_COLS  = 3'd0;
	localparam logic [2:0] REG_SECOND_COLS = 3'd1;
	localparam logic [2:0] REG_CUT_FIRST   = 3'd2;
	localparam logic [2:0] REG_CUT_SECOND  = 3'd3;
	localparam logic [2:0] REG_BLEND_WIDTH = 3'd4;

	// Work codes from front to back
	typedef logic [1:0] op_t;
	localparam op_t OP_DROP  = 2'd0;
	localparam op_t OP_PASS  = 2'd1;
	localparam op_t OP_BLEND = 2'd2;

	typedef struct packed {
		logic             kind;
		logic [PIX_W-1:0] pixel;
	} pix_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             out_valid;
		logic             end_of_row;
		logic             order_error;
		logic             setup_error;
	} res_item_t;

	typedef struct packed {
		logic [COL_W-1:0]   first_cols;
		logic [COL_W-1:0]   second_cols;
		logic [CUT_W-1:0]   cut_first;
		logic [CUT_W-1:0]   cut_second;
		logic [BLEND_W-1:0] blend_width;
	} cfg_t;

	typedef struct packed {
		op_t                 op;
		logic [PIX_W-1:0]    pixel;
		logic [PIX_W-1:0]    stored;
		logic [BLEND_AW-1:0] idx;
		logic                eor;
		logic                oerr;
		logic                serr;
	} work_t;

endpackage

// ----- sv/isb_front.sv -----
// Front end: accepts pixels, tracks row position, keeps the stripe and classifies work.
module isb_front (
	input  logic              clk,
	input  logic              arst_n,
	input  isb_pkg::pix_item_t pix,
	input  logic              pix_valid,
	output logic              pix_ready,
	input  isb_pkg::cfg_t     cfg,
	output isb_pkg::work_t    push_item,
	output logic              push,
	input  logic              q_full
);
	import isb_pkg::*;

	logic [COL_W-1:0]    col_q, col_n;
	logic                phase_q, phase_n;
	logic                vld_s1;
	work_t               work_s1, work_n;
	logic [PIX_W-1:0]    stored_s1;
	logic                take;
	logic                store_en;
	logic                bad;
	logic [BLEND_AW-1:0] wr_addr, rd_addr;
	logic [COL_W-1:0]    hi, lo, last1, last2, idx_full, cf_sum, cs_sum;
	logic [PIX_W-1:0]    stripe_mem [MAX_BLEND];

	assign pix_ready = !vld_s1 || !q_full;
	assign take      = pix_valid && pix_ready;
	assign push      = vld_s1 && !q_full;

	always_comb begin
		cf_sum   = {1'b0, cfg.cut_first} + {{(COL_W-BLEND_W){1'b0}}, cfg.blend_width};
		cs_sum   = {1'b0, cfg.cut_second} + {{(COL_W-BLEND_W){1'b0}}, cfg.blend_width};
		hi       = cfg.first_cols - {1'b0, cfg.cut_first};
		lo       = hi - {{(COL_W-BLEND_W){1'b0}}, cfg.blend_width};
		last1    = cfg.first_cols - COL_W'(1);
		last2    = cfg.second_cols - COL_W'(1);
		idx_full = col_q - {1'b0, cfg.cut_second};
		wr_addr  = BLEND_AW'(col_q - lo);
		rd_addr  = idx_full[BLEND_AW-1:0];
		bad = (cfg.blend_width > BLEND_W'(MAX_BLEND)) ||
		      (cfg.first_cols > COL_W'(MAX_COLS)) ||
		      (cfg.second_cols > COL_W'(MAX_COLS)) ||
		      (cf_sum >= cfg.first_cols) || (cs_sum >= cfg.second_cols);

		work_n       = '0;
		work_n.op    = OP_DROP;
		work_n.pixel = pix.pixel;
		work_n.idx   = idx_full[BLEND_AW-1:0];
		col_n        = col_q;
		phase_n      = phase_q;
		store_en     = 1'b0;

		if (bad) begin
			work_n.serr = 1'b1;
		end else if (pix.kind != phase_q) begin
			work_n.oerr = 1'b1;
		end else if (!phase_q) begin
			if (col_q < lo) begin
				work_n.op = OP_PASS;
			end else if (col_q < hi) begin
				store_en = 1'b1;
			end
			if (col_q >= last1) begin
				col_n   = '0;
				phase_n = 1'b1;
			end else begin
				col_n = col_q + COL_W'(1);
			end
		end else begin
			if (col_q >= {1'b0, cfg.cut_second}) begin
				if (idx_full < {{(COL_W-BLEND_W){1'b0}}, cfg.blend_width}) begin
					work_n.op = OP_BLEND;
				end else begin
					work_n.op = OP_PASS;
				end
			end
			if (col_q >= last2) begin
				work_n.eor = (col_q >= {1'b0, cfg.cut_second});
				col_n      = '0;
				phase_n    = 1'b0;
			end else begin
				col_n = col_q + COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			col_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			if (take) begin
				vld_s1  <= 1'b1;
				col_q   <= col_n;
				phase_q <= phase_n;
			end else if (push) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			work_s1 <= work_n;
		end
	end

	// Stripe store: written in the first-image phase, read for blend pixels
	always_ff @(posedge clk) begin
		if (take && store_en) begin
			stripe_mem[wr_addr] <= pix.pixel;
		end
		if (take) begin
			stored_s1 <= stripe_mem[rd_addr];
		end
	end

	always_comb begin
		push_item        = work_s1;
		push_item.stored = stored_s1;
	end

endmodule

// ----- sv/isb_queue.sv -----
// Short work queue between front end and back end.
module isb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  isb_pkg::work_t push_item,
	output logic           full,
	input  logic           pop,
	output isb_pkg::work_t head,
	output logic           empty
);
	import isb_pkg::*;

	work_t               slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_AW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_AW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QUEUE_CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QUEUE_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- sv/isb_back.sv -----
// Back end: blend arithmetic with a bit-serial divider and the result register.
module isb_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  isb_pkg::work_t              head,
	input  logic                        empty,
	output logic                        pop,
	input  logic [isb_pkg::BLEND_W-1:0] blend_width,
	output isb_pkg::res_item_t          res,
	output logic                        res_valid,
	input  logic                        res_ready
);
	import isb_pkg::*;

	localparam logic [2:0] ST_TAKE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUM  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam int PROD_W = BLEND_W + PIX_W;
	localparam int REM_W  = PROD_W + 1;
	localparam int CNT_W  = $clog2(PIX_W);

	logic [2:0]          st_q;
	logic [PIX_W-1:0]    a_q, b_q, quo_q;
	logic [BLEND_AW-1:0] idx_q;
	logic                eor_q;
	logic [PROD_W-1:0]   pa_q, pb_q;
	logic [REM_W-1:0]    rem_q, trial, n_sum, rem_init;
	logic [CNT_W-1:0]    cnt_q;
	logic [BLEND_W-1:0]  wi, ip1;
	logic [BLEND_W:0]    dp, d2;
	logic                free, ge, load_pass, load_blend;
	res_item_t           res_q;
	logic                res_valid_q;

	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_comb begin
		free     = !res_valid_q || res_ready;
		wi       = blend_width - {1'b0, idx_q};
		ip1      = {1'b0, idx_q} + BLEND_W'(1);
		dp       = {1'b0, blend_width} + (BLEND_W+1)'(1);
		d2       = {dp[BLEND_W-1:0], 1'b0};
		trial    = REM_W'(d2) << cnt_q;
		ge       = (rem_q >= trial);
		n_sum    = REM_W'(pa_q) + REM_W'(pb_q);
		// twice the numerator plus the divisor gives round half up
		rem_init = {n_sum[REM_W-2:0], 1'b0} + REM_W'(dp);
		pop        = (st_q == ST_TAKE) && !empty && ((head.op == OP_BLEND) || free);
		load_pass  = pop && (head.op != OP_BLEND);
		load_blend = (st_q == ST_DONE) && free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_TAKE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load_pass || load_blend) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_TAKE: begin
					if (pop && (head.op == OP_BLEND)) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					st_q <= ST_SUM;
				end
				ST_SUM: begin
					cnt_q <= CNT_W'(PIX_W - 1);
					st_q  <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						st_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (free) begin
						st_q <= ST_TAKE;
					end
				end
				default: begin
					st_q <= ST_TAKE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.op == OP_BLEND)) begin
			a_q   <= head.stored;
			b_q   <= head.pixel;
			idx_q <= head.idx;
			eor_q <= head.eor;
		end
		if (st_q == ST_MUL) begin
			pa_q <= {{PIX_W{1'b0}}, wi} * {{BLEND_W{1'b0}}, a_q};
			pb_q <= {{PIX_W{1'b0}}, ip1} * {{BLEND_W{1'b0}}, b_q};
		end
		if (st_q == ST_SUM) begin
			rem_q <= rem_init;
			quo_q <= '0;
		end
		if (st_q == ST_DIV) begin
			if (ge) begin
				rem_q <= rem_q - trial;
			end
			quo_q <= {quo_q[PIX_W-2:0], ge};
		end
		if (load_pass) begin
			res_q.out_pixel   <= (head.op == OP_PASS) ? head.pixel : '0;
			res_q.out_valid   <= (head.op == OP_PASS);
			res_q.end_of_row  <= head.eor;
			res_q.order_error <= head.oerr;
			res_q.setup_error <= head.serr;
		end else if (load_blend) begin
			res_q.out_pixel   <= quo_q;
			res_q.out_valid   <= 1'b1;
			res_q.end_of_row  <= eor_q;
			res_q.order_error <= 1'b0;
			res_q.setup_error <= 1'b0;
		end
	end

endmodule

// ----- sv/image_seam_linear_blend_top.sv -----
// Image seam linear blend: stitches two rows with a feathered transition stripe.
// Path: an accepted pixel is registered in the front end, then in a queue slot, then in the result register.
// Throughput: one pass-through or dropped pixel per cycle while res_ready does not stall; a blended
// pixel holds the back end for the product, the sum, then one quotient bit per cycle of the serial divider.
// Reset: arst_n clears registers to their defaults, the row position, the queue and the
// result valid flag; the stripe store is not cleared and is filled by each row's first image.
module image_seam_linear_blend_top (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pix_valid,
	output logic                   pix_ready,
	input  isb_pkg::pix_item_t     pix,
	output logic                   res_valid,
	input  logic                   res_ready,
	output isb_pkg::res_item_t     res,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [4:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);
	import isb_pkg::*;

	cfg_t  cfg_q;
	work_t push_item, head;
	logic  push, pop, q_full, q_empty;
	logic  wr_en;

	// APB access: no wait states
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_cols  <= COL_W'(MAX_COLS);
			cfg_q.second_cols <= COL_W'(MAX_COLS);
			cfg_q.cut_first   <= '0;
			cfg_q.cut_second  <= '0;
			cfg_q.blend_width <= '0;
		end else if (wr_en) begin
			unique case (paddr[4:2])
				REG_FIRST_COLS:  cfg_q.first_cols  <= pwdata[COL_W-1:0];
				REG_SECOND_COLS: cfg_q.second_cols <= pwdata[COL_W-1:0];
				REG_CUT_FIRST:   cfg_q.cut_first   <= pwdata[CUT_W-1:0];
				REG_CUT_SECOND:  cfg_q.cut_second  <= pwdata[CUT_W-1:0];
				REG_BLEND_WIDTH: cfg_q.blend_width <= pwdata[BLEND_W-1:0];
				default: begin
					// drop writes outside the register list
				end
			endcase
		end
	end

	// Read back the register image
	always_comb begin
		unique case (paddr[4:2])
			REG_FIRST_COLS:  prdata = 32'(cfg_q.first_cols);
			REG_SECOND_COLS: prdata = 32'(cfg_q.second_cols);
			REG_CUT_FIRST:   prdata = 32'(cfg_q.cut_first);
			REG_CUT_SECOND:  prdata = 32'(cfg_q.cut_second);
			REG_BLEND_WIDTH: prdata = 32'(cfg_q.blend_width);
			default:         prdata = '0;
		endcase
	end

	// Front: accept each transaction, classify it and fetch its stripe partner
	isb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.cfg       (cfg_q),
		.push_item (push_item),
		.push      (push),
		.q_full    (q_full)
	);

	// Queue: decouple classification from the slower blend arithmetic
	isb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head),
		.empty     (q_empty)
	);

	// Back: compute blended pixels and hold each result until it is taken
	isb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.blend_width (cfg_q.blend_width),
		.res         (res),
		.res_valid   (res_valid),
		.res_ready   (res_ready)
	);

endmodule
